>>> src/psh_pkg.sv
// psh_pkg: shared types, constants and the permutation table of the string hash
// used by the channel interfaces, the modulo unit and the top level
`default_nettype none

package psh_pkg;

    localparam int CHAR_W   = 8;
    localparam int HASH_W   = 8;
    localparam int BUCKET_W = 16;

    // register map (index = byte address / 4)
    localparam logic [1:0] REG_MAX_CHARS  = 2'd0;
    localparam logic [1:0] REG_TABLE_SIZE = 2'd1;
    localparam logic [1:0] REG_FOLD_CASE  = 2'd2;

    // reset values of the registers
    localparam logic [7:0]  MAX_CHARS_RST  = 8'd64;
    localparam logic [15:0] TABLE_SIZE_RST = 16'd1024;
    localparam logic        FOLD_CASE_RST  = 1'b0;

    // largest bucket count served by the narrow hash alone
    localparam logic [16:0] NARROW_LIMIT = 17'd256;
    localparam logic [7:0]  SEEN_MAX     = 8'hff;

    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [HASH_W-1:0]   t_hash;
    typedef logic [BUCKET_W-1:0] t_bucket;

    // request into the modulo unit
    typedef struct packed {
        logic    valid;
        t_bucket dividend;
        t_bucket divisor;
    } t_mod_req;

    localparam t_hash PERM_TAB [256] = '{
        8'd1, 8'd87, 8'd49, 8'd12, 8'd176, 8'd178, 8'd102, 8'd166,
        8'd121, 8'd193, 8'd6, 8'd84, 8'd249, 8'd230, 8'd44, 8'd163,
        8'd14, 8'd197, 8'd213, 8'd181, 8'd161, 8'd85, 8'd218, 8'd80,
        8'd64, 8'd239, 8'd24, 8'd226, 8'd236, 8'd142, 8'd38, 8'd200,
        8'd110, 8'd177, 8'd104, 8'd103, 8'd141, 8'd253, 8'd255, 8'd50,
        8'd77, 8'd101, 8'd81, 8'd18, 8'd45, 8'd96, 8'd31, 8'd222,
        8'd25, 8'd107, 8'd190, 8'd70, 8'd86, 8'd237, 8'd240, 8'd34,
        8'd72, 8'd242, 8'd20, 8'd214, 8'd244, 8'd227, 8'd149, 8'd235,
        8'd97, 8'd234, 8'd57, 8'd22, 8'd60, 8'd250, 8'd82, 8'd175,
        8'd208, 8'd5, 8'd127, 8'd199, 8'd111, 8'd62, 8'd135, 8'd248,
        8'd174, 8'd169, 8'd211, 8'd58, 8'd66, 8'd154, 8'd106, 8'd195,
        8'd245, 8'd171, 8'd17, 8'd187, 8'd182, 8'd179, 8'd0, 8'd243,
        8'd132, 8'd56, 8'd148, 8'd75, 8'd128, 8'd133, 8'd158, 8'd100,
        8'd130, 8'd126, 8'd91, 8'd13, 8'd153, 8'd246, 8'd216, 8'd219,
        8'd119, 8'd68, 8'd223, 8'd78, 8'd83, 8'd88, 8'd201, 8'd99,
        8'd122, 8'd11, 8'd92, 8'd32, 8'd136, 8'd114, 8'd52, 8'd10,
        8'd138, 8'd30, 8'd48, 8'd183, 8'd156, 8'd35, 8'd61, 8'd26,
        8'd143, 8'd74, 8'd251, 8'd94, 8'd129, 8'd162, 8'd63, 8'd152,
        8'd170, 8'd7, 8'd115, 8'd167, 8'd241, 8'd206, 8'd3, 8'd150,
        8'd55, 8'd59, 8'd151, 8'd220, 8'd90, 8'd53, 8'd23, 8'd131,
        8'd125, 8'd173, 8'd15, 8'd238, 8'd79, 8'd95, 8'd89, 8'd16,
        8'd105, 8'd137, 8'd225, 8'd224, 8'd217, 8'd160, 8'd37, 8'd123,
        8'd118, 8'd73, 8'd2, 8'd157, 8'd46, 8'd116, 8'd9, 8'd145,
        8'd134, 8'd228, 8'd207, 8'd212, 8'd202, 8'd215, 8'd69, 8'd229,
        8'd27, 8'd188, 8'd67, 8'd124, 8'd168, 8'd252, 8'd42, 8'd4,
        8'd29, 8'd108, 8'd21, 8'd247, 8'd19, 8'd205, 8'd39, 8'd203,
        8'd233, 8'd40, 8'd186, 8'd147, 8'd198, 8'd192, 8'd155, 8'd33,
        8'd164, 8'd191, 8'd98, 8'd204, 8'd165, 8'd180, 8'd117, 8'd76,
        8'd140, 8'd36, 8'd210, 8'd172, 8'd41, 8'd54, 8'd159, 8'd8,
        8'd185, 8'd232, 8'd113, 8'd196, 8'd231, 8'd47, 8'd146, 8'd120,
        8'd51, 8'd65, 8'd28, 8'd144, 8'd254, 8'd221, 8'd93, 8'd189,
        8'd194, 8'd139, 8'd112, 8'd43, 8'd71, 8'd109, 8'd184, 8'd209
    };

    // ascii upper case letters to lower case, everything else unchanged
    function automatic t_char to_lower(input t_char c);
        if (c >= 8'h41 && c <= 8'h5a) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/psh_if.sv
// psh_char_if / psh_bucket_if: valid-ready channels of the string hash
// payload types come from psh_pkg
`default_nettype none

interface psh_char_if
    import psh_pkg::*;
();
    logic  valid;
    logic  ready;
    t_char char_byte;
    logic  end_of_string;

    modport source (output valid, output char_byte, output end_of_string, input ready);
    modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface psh_bucket_if
    import psh_pkg::*;
();
    logic    valid;
    logic    ready;
    t_bucket bucket;

    modport source (output valid, output bucket, input ready);
    modport sink   (input valid, input bucket, output ready);
endinterface

`default_nettype wire

>>> src/pearson_string_hash.sv
// pearson_string_hash: top level of the streaming 8/16-bit string hash
// depends on psh_pkg, psh_char_if / psh_bucket_if and psh_mod
//
// Use: a string arrives on i_char one byte per request, end_of_string set on
// its final byte. The running hash sits in the registered output of the
// permutation table lookup, so one byte is taken every cycle while no
// request is pending. On the final byte the hash value and the bucket
// count are latched as one pending request for the modulo unit, which
// computes one remainder bit per cycle and holds its result on o_bucket
// until the sink takes it. The request passes the pending register and
// then the modulo unit; a zero table_size skips the reduction.
// Throughput: one byte per cycle within a string; every byte of the next
// string waits while a pending request is not yet in the modulo unit,
// so each string end waits until the modulo unit has passed on its last result.
// When the sink stalls, the modulo unit holds its result, the pending request
// waits, and i_char.ready falls once a further string end is pending.
// Reset (i_rst_n low, synchronous) clears the string state, empties the
// pipeline and restores max_chars 64, table_size 1024, fold_case 0.
// Registers on the APB port: 0x0 max_chars, 0x4 table_size, 0x8 fold_case.
`default_nettype none

module pearson_string_hash
    import psh_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    psh_char_if.sink     i_char,
    psh_bucket_if.source o_bucket,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // configuration registers
    logic [7:0] r_max_chars;
    t_bucket    r_table_size;
    logic       r_fold_case;

    // string state
    t_hash      r_narrow;
    t_hash      r_second;
    logic [7:0] r_seen;
    logic       r_stopped;
    logic       r_nonempty;

    // pending request into the modulo unit
    t_mod_req   r_pend;

    t_hash      n_narrow;
    t_hash      n_second;
    logic       n_stopped;
    logic       n_nonempty;
    logic [7:0] n_seen;

    logic       w_wr;
    logic       w_acc;
    logic       w_in_limit;
    t_char      w_hb;
    t_bucket    w_final;
    logic       w_mod_ready;

    // apb register access
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars  <= MAX_CHARS_RST;
            r_table_size <= TABLE_SIZE_RST;
            r_fold_case  <= FOLD_CASE_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MAX_CHARS:  r_max_chars  <= pwdata[7:0];
                REG_TABLE_SIZE: r_table_size <= pwdata[15:0];
                REG_FOLD_CASE:  r_fold_case  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_CHARS:  prdata = {24'd0, r_max_chars};
            REG_TABLE_SIZE: prdata = {16'd0, r_table_size};
            REG_FOLD_CASE:  prdata = {31'd0, r_fold_case};
            default:        prdata = '0;
        endcase
    end

    // input request handshake
    assign i_char.ready = !r_pend.valid;
    assign w_acc        = i_char.valid && !r_pend.valid;

    // per byte update through the permutation table
    always_comb begin
        n_narrow   = r_narrow;
        n_second   = r_second;
        n_stopped  = r_stopped;
        n_nonempty = r_nonempty;
        w_in_limit = (r_seen < r_max_chars);
        w_hb       = r_fold_case ? to_lower(i_char.char_byte) : i_char.char_byte;
        if (!r_stopped) begin
            if (i_char.char_byte == '0) begin
                n_stopped = 1'b1;
            end else begin
                if (w_in_limit) begin
                    n_narrow = PERM_TAB[r_narrow ^ w_hb];
                end
                if (r_seen == '0) begin
                    n_nonempty = 1'b1;
                    n_second   = i_char.char_byte + 8'd1;
                end else if (w_in_limit) begin
                    n_second = PERM_TAB[r_second ^ i_char.char_byte];
                end
            end
        end
        n_seen = (r_seen == SEEN_MAX) ? r_seen : r_seen + 8'd1;
    end

    // narrow or wide hash value at the end of a string
    always_comb begin
        if (!r_fold_case && ({1'b0, r_table_size} > NARROW_LIMIT) && n_nonempty) begin
            w_final = {n_narrow, n_second};
        end else begin
            w_final = {8'd0, n_narrow};
        end
    end

    // string state registers, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow   <= '0;
            r_second   <= '0;
            r_seen     <= '0;
            r_stopped  <= 1'b0;
            r_nonempty <= 1'b0;
        end else if (w_acc) begin
            if (i_char.end_of_string) begin
                r_narrow   <= '0;
                r_second   <= '0;
                r_seen     <= '0;
                r_stopped  <= 1'b0;
                r_nonempty <= 1'b0;
            end else begin
                r_narrow   <= n_narrow;
                r_second   <= n_second;
                r_seen     <= n_seen;
                r_stopped  <= n_stopped;
                r_nonempty <= n_nonempty;
            end
        end
    end

    // pending request register in front of the modulo unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend.valid <= 1'b0;
        end else if (w_acc && i_char.end_of_string) begin
            r_pend.valid    <= 1'b1;
            r_pend.dividend <= w_final;
            r_pend.divisor  <= r_table_size;
        end else if (w_mod_ready) begin
            r_pend.valid <= 1'b0;
        end
    end

    // bucket reduction
    psh_mod u_mod (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (r_pend),
        .o_req_ready  (w_mod_ready),
        .o_res_valid  (o_bucket.valid),
        .o_res_bucket (o_bucket.bucket),
        .i_res_ready  (o_bucket.ready)
    );

endmodule

`default_nettype wire

>>> src/psh_mod.sv
// psh_mod: bucket reduction, hash value modulo the bucket count
// restoring remainder, one bit per cycle; types from psh_pkg
`default_nettype none

module psh_mod
    import psh_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_mod_req i_req,
    output logic     o_req_ready,
    output logic     o_res_valid,
    output t_bucket  o_res_bucket,
    input  wire      i_res_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int CNT_W = $clog2(BUCKET_W);

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    t_bucket          r_rem;
    t_bucket          r_dvd;
    t_bucket          r_div;

    logic [BUCKET_W:0] w_shifted;
    logic [BUCKET_W:0] w_diff;
    logic              w_take;
    logic              w_accept;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_shifted = {r_rem, r_dvd[BUCKET_W-1]};
        w_diff    = w_shifted - {1'b0, r_div};
        w_take    = (w_shifted >= {1'b0, r_div});
    end

    assign w_accept = i_req.valid && o_req_ready;

    assign o_req_ready  = (r_state == ST_IDLE) || (r_state == ST_DONE && i_res_ready);
    assign o_res_valid  = (r_state == ST_DONE);
    assign o_res_bucket = r_rem;

    // control: a zero bucket count passes the hash straight through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE, ST_DONE: begin
                    if (w_accept) begin
                        r_state <= (i_req.divisor == '0) ? ST_DONE : ST_RUN;
                        r_cnt   <= '0;
                    end else if (r_state == ST_DONE && i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(BUCKET_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_div <= i_req.divisor;
            if (i_req.divisor == '0) begin
                r_rem <= i_req.dividend;
            end else begin
                r_rem <= '0;
            end
            r_dvd <= i_req.dividend;
        end else if (r_state == ST_RUN) begin
            r_rem <= w_take ? w_diff[BUCKET_W-1:0] : w_shifted[BUCKET_W-1:0];
            r_dvd <= {r_dvd[BUCKET_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire
